### hdl/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define BLBR_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is low.
`define BLBR_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### hdl/blbr_pkg.sv
// ----------------------------------------------------------------------------
// blbr_pkg
// Shared constants, types and helpers of the battery level LED bar renderer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package blbr_pkg;

    // Default geometry
    localparam int STRIP_LENGTH_DEF = 16;
    localparam int BAR_LENGTH_DEF   = 8;

    // Lit count is carried wide enough for the largest bar (32)
    localparam int LIT_W = 6;

    // Frames buffered between the level pipeline and the pixel output
    localparam int FIFO_DEPTH = 4;

    // Register reset values
    localparam logic [15:0] EMPTY_RESET  = 16'd3300;
    localparam logic [15:0] FULL_RESET   = 16'd4200;
    localparam logic [7:0]  BRIGHT_RESET = 8'd255;

    // Register indexes
    localparam logic [1:0] CFG_EMPTY  = 2'd0;
    localparam logic [1:0] CFG_FULL   = 2'd1;
    localparam logic [1:0] CFG_BRIGHT = 2'd2;

    // Segment color bands
    localparam int          RED_END     = 2;
    localparam int          AMBER_END   = 5;
    localparam logic [7:0]  AMBER_GREEN = 8'd160;

    // How the lit count of a sample is decided
    typedef enum logic [1:0] {
        LVL_ZERO,
        LVL_FULL,
        LVL_DIV
    } lvl_sel_t;

    // One frame descriptor
    typedef struct packed {
        logic [LIT_W-1:0] lit_count;
        logic [7:0]       amber_g;
        logic [7:0]       bright;
    } frame_t;

    // floor(x / 255), exact for x below 65280
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'(x >> 8) + 17'd1;
        return t[15:8];
    endfunction

endpackage

### hdl/blbr_level_pipe.sv
// ----------------------------------------------------------------------------
// blbr_level_pipe
// Turns a voltage sample into a lit count: range setup, scaled numerator,
// then one restoring-division stage per quotient bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blbr_level_pipe #(
    parameter int BAR_LENGTH = blbr_pkg::BAR_LENGTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [15:0]     battery_mv,
    input  logic [15:0]     empty_level_mv,
    input  logic [15:0]     full_level_mv,
    input  logic [7:0]      bar_brightness,
    output logic            out_valid,
    output blbr_pkg::frame_t out_frame
);
    import blbr_pkg::*;

    localparam int NW = $clog2(BAR_LENGTH + 1);
    localparam int RW = 16 + NW;

    // Stage 1: compare against limits, differences, amber product
    logic        s1_valid_reg;
    lvl_sel_t    s1_sel_reg,    s1_sel_next;
    logic [15:0] s1_above_reg,  s1_above_next;
    logic [15:0] s1_range_reg,  s1_range_next;
    logic [15:0] s1_prod_reg,   s1_prod_next;
    logic [7:0]  s1_bright_reg;

    // Division stages; index 0 holds the numerator
    logic           d_valid_reg  [0:NW];
    lvl_sel_t       d_sel_reg    [0:NW];
    logic [RW-1:0]  d_rem_reg    [0:NW];
    logic [15:0]    d_range_reg  [0:NW];
    logic [NW-1:0]  d_q_reg      [0:NW];
    logic [7:0]     d_amber_reg  [0:NW];
    logic [7:0]     d_bright_reg [0:NW];

    logic [RW-1:0]    num_next;
    logic [LIT_W-1:0] lit_next;

    always_comb
    begin
        if (battery_mv <= empty_level_mv || full_level_mv <= empty_level_mv)
        begin
            s1_sel_next = LVL_ZERO;
        end
        else if (battery_mv >= full_level_mv)
        begin
            s1_sel_next = LVL_FULL;
        end
        else
        begin
            s1_sel_next = LVL_DIV;
        end
        s1_above_next = battery_mv - empty_level_mv;
        s1_range_next = full_level_mv - empty_level_mv;
        s1_prod_next  = 16'(AMBER_GREEN) * 16'(bar_brightness);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sel_reg    <= s1_sel_next;
        s1_above_reg  <= s1_above_next;
        s1_range_reg  <= s1_range_next;
        s1_prod_reg   <= s1_prod_next;
        s1_bright_reg <= bar_brightness;
    end

    // Stage 2: ceiling numerator above*BAR + range - 1, dimmed amber
    assign num_next = RW'(s1_above_reg) * RW'(BAR_LENGTH) + RW'(s1_range_reg) - RW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg[0] <= 1'b0;
        end
        else
        begin
            d_valid_reg[0] <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_sel_reg[0]    <= s1_sel_reg;
        d_rem_reg[0]    <= num_next;
        d_range_reg[0]  <= s1_range_reg;
        d_q_reg[0]      <= '0;
        d_amber_reg[0]  <= div255(s1_prod_reg);
        d_bright_reg[0] <= s1_bright_reg;
    end

    // One quotient bit per stage, most significant first
    for (genvar j = 0; j < NW; j++)
    begin : g_div
        localparam int K = NW - 1 - j;

        logic [RW-1:0] dsh;
        logic          fits;
        logic [RW-1:0] rem_next;
        logic [NW-1:0] q_next;

        always_comb
        begin
            dsh      = RW'(d_range_reg[j]) << K;
            fits     = d_rem_reg[j] >= dsh;
            rem_next = fits ? d_rem_reg[j] - dsh : d_rem_reg[j];
            q_next   = d_q_reg[j];
            q_next[K] = fits;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                d_valid_reg[j+1] <= 1'b0;
            end
            else
            begin
                d_valid_reg[j+1] <= d_valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            d_sel_reg[j+1]    <= d_sel_reg[j];
            d_rem_reg[j+1]    <= rem_next;
            d_range_reg[j+1]  <= d_range_reg[j];
            d_q_reg[j+1]      <= q_next;
            d_amber_reg[j+1]  <= d_amber_reg[j];
            d_bright_reg[j+1] <= d_bright_reg[j];
        end
    end

    // Final lit count with limit cases and saturation
    always_comb
    begin
        case (d_sel_reg[NW])
            LVL_ZERO: lit_next = '0;
            LVL_FULL: lit_next = LIT_W'(BAR_LENGTH);
            default:
            begin
                if (LIT_W'(d_q_reg[NW]) > LIT_W'(BAR_LENGTH))
                begin
                    lit_next = LIT_W'(BAR_LENGTH);
                end
                else
                begin
                    lit_next = LIT_W'(d_q_reg[NW]);
                end
            end
        endcase
    end

    assign out_valid           = d_valid_reg[NW];
    assign out_frame.lit_count = lit_next;
    assign out_frame.amber_g   = d_amber_reg[NW];
    assign out_frame.bright    = d_bright_reg[NW];

endmodule

### hdl/blbr_frame_fifo.sv
// ----------------------------------------------------------------------------
// blbr_frame_fifo
// Small queue of frame descriptors waiting for the pixel output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blbr_frame_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  blbr_pkg::frame_t push_frame,
    input  logic             pop,
    output blbr_pkg::frame_t head_frame,
    output logic             empty
);
    import blbr_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    frame_t        fifo_mem_reg [FIFO_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;

    // Pointer and occupancy update; upstream credits keep pushes below full
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem_reg[wr_ptr_reg] <= push_frame;
        end
    end

    assign head_frame = fifo_mem_reg[rd_ptr_reg];
    assign empty      = (count_reg == '0);

endmodule

### hdl/blbr_pixel_out.sv
// ----------------------------------------------------------------------------
// blbr_pixel_out
// Walks the strip one pixel per cycle and drives the registered pixel ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blbr_pixel_out #(
    parameter int STRIP_LENGTH = blbr_pkg::STRIP_LENGTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fifo_empty,
    input  blbr_pkg::frame_t fifo_frame,
    output logic             pop,
    output logic             result_valid,
    output logic [5:0]       led_index,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue,
    output logic             frame_end
);
    import blbr_pkg::*;

    localparam int PW = $clog2(STRIP_LENGTH);

    logic          active_reg, active_next;
    logic [PW-1:0] pix_reg,    pix_next;
    frame_t        frame_reg,  frame_next;
    logic          last_pix;

    logic [PW-1:0]    mirror;
    logic [PW-1:0]    lo_seg, hi_seg;
    logic [LIT_W-1:0] seg;
    logic             lit;
    logic [7:0]       red_next, green_next;

    logic       valid_reg;
    logic [5:0] index_reg;
    logic [7:0] red_reg, green_reg;
    logic       end_reg;

    // Frame sequencing; next frame starts right after the last pixel
    assign last_pix = (pix_reg == PW'(STRIP_LENGTH - 1));
    assign pop      = !fifo_empty && (!active_reg || last_pix);

    always_comb
    begin
        active_next = active_reg;
        pix_next    = pix_reg;
        frame_next  = frame_reg;
        if (pop)
        begin
            active_next = 1'b1;
            pix_next    = '0;
            frame_next  = fifo_frame;
        end
        else if (active_reg && last_pix)
        begin
            active_next = 1'b0;
        end
        else if (active_reg)
        begin
            pix_next = pix_reg + PW'(1);
        end
    end

    // A pixel shows the higher of its two mirrored segments that is lit
    always_comb
    begin
        mirror = PW'(STRIP_LENGTH - 1) - pix_reg;
        lo_seg = (pix_reg < mirror) ? pix_reg : mirror;
        hi_seg = (pix_reg < mirror) ? mirror : pix_reg;
        if (LIT_W'(hi_seg) < frame_reg.lit_count)
        begin
            seg = LIT_W'(hi_seg);
            lit = 1'b1;
        end
        else if (LIT_W'(lo_seg) < frame_reg.lit_count)
        begin
            seg = LIT_W'(lo_seg);
            lit = 1'b1;
        end
        else
        begin
            seg = '0;
            lit = 1'b0;
        end

        // Red band, amber band, then green
        red_next   = '0;
        green_next = '0;
        if (lit)
        begin
            if (seg < LIT_W'(RED_END))
            begin
                red_next = frame_reg.bright;
            end
            else if (seg < LIT_W'(AMBER_END))
            begin
                red_next   = frame_reg.bright;
                green_next = frame_reg.amber_g;
            end
            else
            begin
                green_next = frame_reg.bright;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pix_reg    <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            pix_reg    <= pix_next;
            valid_reg  <= active_reg;
        end
    end

    // Frame descriptor and output payload
    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
        index_reg <= 6'(pix_reg);
        red_reg   <= red_next;
        green_reg <= green_next;
        end_reg   <= active_reg && last_pix;
    end

    assign result_valid = valid_reg;
    assign led_index    = index_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = '0;
    assign frame_end    = end_reg && valid_reg;

endmodule

### hdl/battery_level_led_bar_renderer_core.sv
// ----------------------------------------------------------------------------
// battery_level_led_bar_renderer_core
// Battery voltage to mirrored red/amber/green LED bar frame renderer.
// ----------------------------------------------------------------------------
// A sample is taken with start while busy is low. Each sample yields a frame
// of STRIP_LENGTH pixels, one per clock in ascending led_index order, each
// marked by a one-cycle result_valid strobe; frame_end flags the last pixel.
// The receiver cannot stall, so pixels must be captured when strobed. A
// sample passes the sample register, the numerator register, the division
// stages, the frame FIFO and the frame register before its first pixel is
// registered out. Samples can be taken on consecutive cycles until four
// frames are pending; from then on busy holds intake off until the pixel
// output starts the next frame. Queued frames follow each other with no gap.
// Configuration writes are always accepted (cfg_ready is high) and must only
// be made while no frame is pending; writes to an unused index are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module battery_level_led_bar_renderer_core #(
    parameter int STRIP_LENGTH = blbr_pkg::STRIP_LENGTH_DEF,
    parameter int BAR_LENGTH   = blbr_pkg::BAR_LENGTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Sample command
    input  logic        start,
    output logic        busy,
    input  logic [15:0] battery_mv,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // Pixel results
    output logic        result_valid,
    output logic [5:0]  led_index,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic        frame_end
);
    import blbr_pkg::*;

    localparam int CRW = $clog2(FIFO_DEPTH + 1);

    logic [15:0]    empty_reg;
    logic [15:0]    full_reg;
    logic [7:0]     bright_reg;
    logic [CRW-1:0] credit_reg, credit_next;

    logic   accept;
    logic   lvl_valid;
    frame_t lvl_frame;
    logic   fifo_pop;
    logic   fifo_empty;
    frame_t fifo_frame;

    // Register file
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_reg  <= EMPTY_RESET;
            full_reg   <= FULL_RESET;
            bright_reg <= BRIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_EMPTY:  empty_reg  <= cfg_data;
                CFG_FULL:   full_reg   <= cfg_data;
                CFG_BRIGHT: bright_reg <= cfg_data[7:0];
                default:    ;
            endcase
        end
    end

    // Credits: samples accepted whose frame has not yet started
    assign accept = start && !busy;
    assign busy   = (credit_reg == CRW'(FIFO_DEPTH));

    always_comb
    begin
        credit_next = credit_reg;
        if (accept && !fifo_pop)
        begin
            credit_next = credit_reg + CRW'(1);
        end
        else if (fifo_pop && !accept)
        begin
            credit_next = credit_reg - CRW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
        end
    end

    blbr_level_pipe #(
        .BAR_LENGTH (BAR_LENGTH)
    ) u_level_pipe (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (accept),
        .battery_mv     (battery_mv),
        .empty_level_mv (empty_reg),
        .full_level_mv  (full_reg),
        .bar_brightness (bright_reg),
        .out_valid      (lvl_valid),
        .out_frame      (lvl_frame)
    );

    blbr_frame_fifo u_frame_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (lvl_valid),
        .push_frame (lvl_frame),
        .pop        (fifo_pop),
        .head_frame (fifo_frame),
        .empty      (fifo_empty)
    );

    blbr_pixel_out #(
        .STRIP_LENGTH (STRIP_LENGTH)
    ) u_pixel_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .fifo_empty   (fifo_empty),
        .fifo_frame   (fifo_frame),
        .pop          (fifo_pop),
        .result_valid (result_valid),
        .led_index    (led_index),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .frame_end    (frame_end)
    );

endmodule

### hdl/blbr_checker.sv
// ----------------------------------------------------------------------------
// blbr_checker
// Port-level checks on the pixel stream of the renderer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module blbr_checker #(
    parameter int STRIP_LENGTH = blbr_pkg::STRIP_LENGTH_DEF
) (
    input logic       clk,
    input logic       rst_n,
    input logic       result_valid,
    input logic [5:0] led_index,
    input logic       frame_end
);

    // Pixels inside a frame come on consecutive cycles in ascending order
    `BLBR_ASSERT_NEXT(a_frame_contiguous, clk, rst_n, result_valid && !frame_end, result_valid && led_index == $past(led_index) + 6'd1)

    // The frame end flag marks exactly the last strip position
    `BLBR_ASSERT_IMPL(a_end_at_last, clk, rst_n, result_valid, frame_end == (led_index == 6'(STRIP_LENGTH - 1)))

    // After a gap a frame always starts at the first pixel
    `BLBR_ASSERT_NEXT(a_start_at_zero, clk, rst_n, !result_valid, !result_valid || led_index == 6'd0)

endmodule

bind battery_level_led_bar_renderer_core blbr_checker #(
    .STRIP_LENGTH (STRIP_LENGTH)
) u_blbr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .led_index    (led_index),
    .frame_end    (frame_end)
);
